FILE: rtl/ahtwm_pkg.sv
// Package for the address hash table with warm marks.
// Holds sizes, operation and status codes, and controller/datapath types.
package ahtwm_pkg;

	localparam int IdSlotsDefault = 1024;
	localparam int BucketSlotsDefault = 2048;

	localparam int OpW = 3;
	localparam int StW = 2;
	localparam int EpochW = 32;
	localparam int IdW = 10;
	localparam int MaskW = 11;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 32;

	localparam logic [OpW-1:0] OP_INSERT = 3'd0;
	localparam logic [OpW-1:0] OP_LOOKUP = 3'd1;
	localparam logic [OpW-1:0] OP_MARK = 3'd2;
	localparam logic [OpW-1:0] OP_QUERY = 3'd3;
	localparam logic [OpW-1:0] OP_RESTORE = 3'd4;

	localparam logic [StW-1:0] ST_OK = 2'd0;
	localparam logic [StW-1:0] ST_MISS = 2'd1;
	localparam logic [StW-1:0] ST_ORDER = 2'd2;
	localparam logic [StW-1:0] ST_FULL = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_EPOCH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MASK = 2'd2;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic last_rd;
		logic bkt_rd;
		logic addr_rd;
		logic eval;
		logic epoch_rd;
		logic finish;
		logic out_take;
	} ahtwm_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bkt_empty;
		logic probe_hit;
		logic probe_over;
		logic out_busy;
	} ahtwm_sts_t;

endpackage

FILE: rtl/ahtwm_ram.sv
// Generic single-port-write RAM with one registered read port.
// No dependencies.
module ahtwm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/ahtwm_datapath.sv
// Datapath: bucket, address and epoch memories, probe pointer and result register.
// Depends on ahtwm_pkg and ahtwm_ram.
module ahtwm_datapath #(
	parameter int IdSlots = ahtwm_pkg::IdSlotsDefault,
	parameter int BucketSlots = ahtwm_pkg::BucketSlotsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ahtwm_pkg::ahtwm_cmd_t         cmd,
	output ahtwm_pkg::ahtwm_sts_t         sts,
	input  logic                          cfg_we,
	input  logic [ahtwm_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [ahtwm_pkg::CfgDataW-1:0] cfg_data,
	input  logic [2:0]                    op,
	input  logic [31:0]                   addr_high,
	input  logic [63:0]                   addr_mid,
	input  logic [63:0]                   addr_low,
	input  logic [9:0]                    restore_id,
	input  logic [31:0]                   restore_epoch,
	output logic [9:0]                    entry_id,
	output logic [1:0]                    status,
	output logic                          is_warm,
	output logic                          journal_valid,
	output logic [31:0]                   epoch_before
);
	import ahtwm_pkg::*;

	localparam int IW = $clog2(IdSlots);
	localparam int BW = $clog2(BucketSlots);

	logic [EpochW-1:0] epoch_now_q;
	logic [IdW-1:0]    limit_q;
	logic [MaskW-1:0]  mask_cfg_q;
	logic [BW-1:0]     mask;

	logic [OpW-1:0] op_q;
	logic [31:0]    hi_q;
	logic [63:0]    mid_q;
	logic [63:0]    lo_q;
	logic [IdW-1:0] rid_q;
	logic [31:0]    repoch_q;

	logic [IW:0]  next_id_q;
	logic [BW-1:0] bkt_ptr_q;
	logic [BW:0]   probe_cnt_q;
	logic [BW:0]   clr_cnt_q;
	logic          clr_done_q;
	logic [IW-1:0] cur_id_q;
	logic          hit_q;
	logic          below_q;

	logic [IW-1:0] bkt_rdata;
	logic          bkt_we;
	logic [BW-1:0] bkt_waddr;
	logic [IW-1:0] bkt_wdata;

	logic [IW-1:0] a_raddr;
	logic          a_we;
	logic [31:0]   ah_rdata;
	logic [63:0]   am_rdata;
	logic [63:0]   al_rdata;
	logic          e_we;
	logic [IW-1:0] e_addr;
	logic [31:0]   e_wdata;
	logic [31:0]   e_rdata;
	logic [IW-1:0] e_raddr;

	logic [IW:0] rid_ext;
	logic        rid_ok;
	logic        full_cap;
	logic        addr_eq;
	logic        addr_lt;

	logic [IdW-1:0] r_id_q;
	logic [StW-1:0] r_st_q;
	logic           r_warm_q;
	logic           r_jv_q;
	logic [31:0]    r_prior_q;
	logic           out_busy_q;

	assign mask = mask_cfg_q[BW-1:0] | '0;
	assign rid_ext = (IW + 1)'(rid_q);
	assign rid_ok = (rid_q != '0) && (rid_ext < next_id_q) && (32'(rid_q) < 32'(IdSlots));
	assign full_cap = ((next_id_q - 1'b1) >= (IW + 1)'(limit_q)) || (32'(next_id_q) >= 32'(IdSlots));
	assign addr_eq = (ah_rdata == hi_q) && (am_rdata == mid_q) && (al_rdata == lo_q);
	assign addr_lt = (ah_rdata != hi_q) ? (ah_rdata < hi_q) :
		(am_rdata != mid_q) ? (am_rdata < mid_q) : (al_rdata < lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_now_q <= '0;
			limit_q <= 10'd1023;
			mask_cfg_q <= 11'd2047;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_EPOCH: epoch_now_q <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data[IdW-1:0];
				CFG_MASK: mask_cfg_q <= cfg_data[MaskW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			hi_q <= addr_high;
			mid_q <= addr_mid;
			lo_q <= addr_low;
			rid_q <= restore_id;
			repoch_q <= restore_epoch;
		end
	end

	// Bucket pointer and probe count walk the active mask with wraparound.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_ptr_q <= '0;
			probe_cnt_q <= '0;
			clr_cnt_q <= '0;
			clr_done_q <= 1'b0;
			next_id_q <= (IW + 1)'(1);
			cur_id_q <= '0;
			hit_q <= 1'b0;
			below_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (BW + 1)'(BucketSlots - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				bkt_ptr_q <= BW'(addr_low) & mask;
				probe_cnt_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.last_rd) begin
				below_q <= (next_id_q == (IW + 1)'(1));
			end
			if (cmd.bkt_rd) begin
				below_q <= below_q | addr_lt;
			end
			if (cmd.addr_rd) begin
				cur_id_q <= bkt_rdata;
			end
			if (cmd.eval) begin
				if (addr_eq) begin
					hit_q <= 1'b1;
				end else begin
					bkt_ptr_q <= (bkt_ptr_q + 1'b1) & mask;
					probe_cnt_q <= probe_cnt_q + 1'b1;
				end
			end
			if (bkt_we && cmd.finish) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// Bucket memory: read at the probe pointer, written by the clear pass or an insert.
	always_comb begin
		bkt_we = 1'b0;
		bkt_waddr = bkt_ptr_q;
		bkt_wdata = next_id_q[IW-1:0];
		if (cmd.clr_step) begin
			bkt_we = 1'b1;
			bkt_waddr = clr_cnt_q[BW-1:0];
			bkt_wdata = '0;
		end else if (cmd.finish && op_q == OP_INSERT && !full_cap && below_q
				&& !hit_q && sts.bkt_empty && !sts.probe_over) begin
			bkt_we = 1'b1;
		end
	end

	ahtwm_ram #(.Width(IW), .Depth(BucketSlots)) u_bkt (
		.clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
		.raddr(bkt_ptr_q), .rdata(bkt_rdata)
	);

	// Address memories are read either at the last inserted id or the probed id.
	assign a_raddr = cmd.last_rd ? IW'(next_id_q - 1'b1) : bkt_rdata;
	assign a_we = bkt_we && !cmd.clr_step;

	ahtwm_ram #(.Width(32), .Depth(IdSlots)) u_ah (
		.clk(clk), .we(a_we), .waddr(next_id_q[IW-1:0]), .wdata(hi_q),
		.raddr(a_raddr), .rdata(ah_rdata)
	);
	ahtwm_ram #(.Width(64), .Depth(IdSlots)) u_am (
		.clk(clk), .we(a_we), .waddr(next_id_q[IW-1:0]), .wdata(mid_q),
		.raddr(a_raddr), .rdata(am_rdata)
	);
	ahtwm_ram #(.Width(64), .Depth(IdSlots)) u_al (
		.clk(clk), .we(a_we), .waddr(next_id_q[IW-1:0]), .wdata(lo_q),
		.raddr(a_raddr), .rdata(al_rdata)
	);

	assign e_raddr = cur_id_q;
	always_comb begin
		e_we = 1'b0;
		e_addr = next_id_q[IW-1:0];
		e_wdata = '0;
		if (a_we) begin
			e_we = 1'b1;
		end else if (cmd.finish && op_q == OP_RESTORE && rid_ok) begin
			e_we = 1'b1;
			e_addr = rid_q[IW-1:0];
			e_wdata = repoch_q;
		end else if (cmd.finish && op_q == OP_MARK && hit_q && e_rdata < epoch_now_q) begin
			e_we = 1'b1;
			e_addr = cur_id_q;
			e_wdata = epoch_now_q;
		end
	end

	ahtwm_ram #(.Width(32), .Depth(IdSlots)) u_ep (
		.clk(clk), .we(e_we), .waddr(e_addr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
		end else if (cmd.finish) begin
			out_busy_q <= 1'b1;
		end else if (cmd.out_take) begin
			out_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			r_id_q <= '0;
			r_st_q <= ST_MISS;
			r_warm_q <= 1'b0;
			r_jv_q <= 1'b0;
			r_prior_q <= '0;
			case (op_q)
				OP_INSERT: begin
					if (full_cap) begin
						r_st_q <= ST_FULL;
					end else if (!below_q || hit_q) begin
						r_st_q <= ST_ORDER;
					end else if (sts.probe_over || !sts.bkt_empty) begin
						r_st_q <= ST_FULL;
					end else begin
						r_st_q <= ST_OK;
						r_id_q <= IdW'(next_id_q);
					end
				end
				OP_LOOKUP, OP_MARK, OP_QUERY: begin
					if (hit_q) begin
						r_st_q <= ST_OK;
						r_id_q <= IdW'(cur_id_q);
						if (op_q == OP_MARK && e_rdata < epoch_now_q) begin
							r_jv_q <= 1'b1;
							r_prior_q <= e_rdata;
						end
						if (op_q == OP_QUERY) begin
							r_warm_q <= (e_rdata >= epoch_now_q);
						end
					end
				end
				OP_RESTORE: begin
					if (rid_ok) begin
						r_st_q <= ST_OK;
						r_id_q <= rid_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign entry_id = r_id_q;
	assign status = r_st_q;
	assign is_warm = r_warm_q;
	assign journal_valid = r_jv_q;
	assign epoch_before = r_prior_q;

	assign sts.clr_done = clr_done_q;
	assign sts.bkt_empty = (bkt_rdata == '0);
	assign sts.probe_hit = addr_eq;
	assign sts.probe_over = (probe_cnt_q > (BW + 1)'(mask));
	assign sts.out_busy = out_busy_q;
endmodule

FILE: rtl/ahtwm_ctrl.sv
// Controller state machine: clear pass, probe sequencing and output handoff.
// Depends on ahtwm_pkg.
module ahtwm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            op,
	output ahtwm_pkg::ahtwm_cmd_t cmd,
	input  ahtwm_pkg::ahtwm_sts_t sts
);
	import ahtwm_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LAST = 4'd2;
	localparam logic [3:0] S_LASTW = 4'd3;
	localparam logic [3:0] S_BRD = 4'd4;
	localparam logic [3:0] S_BWAIT = 4'd5;
	localparam logic [3:0] S_ARD = 4'd6;
	localparam logic [3:0] S_EVAL = 4'd7;
	localparam logic [3:0] S_EPRD = 4'd8;
	localparam logic [3:0] S_FIN = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = sts.out_busy;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.out_take = out_valid && out_ready;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					cmd.clr_step = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					if (op == OP_INSERT) begin
						state_d = S_LAST;
					end else if (op == OP_LOOKUP || op == OP_MARK || op == OP_QUERY) begin
						state_d = S_BRD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_LAST: begin
				cmd.last_rd = 1'b1;
				state_d = S_LASTW;
			end
			S_LASTW: begin
				cmd.bkt_rd = 1'b1;
				state_d = S_BRD;
			end
			S_BRD: begin
				state_d = S_BWAIT;
				if (sts.probe_over) begin
					state_d = S_FIN;
				end
			end
			S_BWAIT: begin
				if (sts.bkt_empty) begin
					state_d = S_FIN;
				end else begin
					cmd.addr_rd = 1'b1;
					state_d = S_ARD;
				end
			end
			S_ARD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				// A hit goes through one epoch read before finishing.
				if (sts.probe_hit) begin
					state_d = S_EPRD;
				end else begin
					state_d = S_BRD;
				end
			end
			S_EPRD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/address_hash_table_with_warm_marks_core.sv
// Top level of the address hash table with warm marks.
// Depends on ahtwm_pkg, ahtwm_ctrl and ahtwm_datapath.
//
//   channel | signals                                   | role
//   in      | in_valid/in_ready, op, addr_*, restore_*  | one operation item
//   out     | out_valid/out_ready, entry_id .. epoch_before | one result item
//   cfg     | cfg_we, cfg_idx, cfg_data                 | register writes
//
// After reset a clearing pass writes every bucket before any item is taken.
// A lookup reads the bucket at the probe pointer and, when it is occupied, the
// address stored for it; a mismatch moves on to the next bucket, an empty
// bucket or an exhausted probe ends it, and a hit reads the epoch before it
// finishes; the loop is bound by the registered bucket and address memory reads.
// An insert first reads the last inserted address for the order check; a restore
// or unused op goes straight to finishing. A new item is taken while the previous
// result waits in the output register; the finishing cycle holds until it is free.
module address_hash_table_with_warm_marks_core #(
	parameter int IdSlots = ahtwm_pkg::IdSlotsDefault,
	parameter int BucketSlots = ahtwm_pkg::BucketSlotsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     op,
	input  logic [31:0]                    addr_high,
	input  logic [63:0]                    addr_mid,
	input  logic [63:0]                    addr_low,
	input  logic [9:0]                     restore_id,
	input  logic [31:0]                    restore_epoch,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [9:0]                     entry_id,
	output logic [1:0]                     status,
	output logic                           is_warm,
	output logic                           journal_valid,
	output logic [31:0]                    epoch_before,
	input  logic                           cfg_we,
	input  logic [ahtwm_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [ahtwm_pkg::CfgDataW-1:0] cfg_data
);
	import ahtwm_pkg::*;

	ahtwm_cmd_t cmd;
	ahtwm_sts_t sts;

	ahtwm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .op(op), .cmd(cmd), .sts(sts)
	);

	ahtwm_datapath #(.IdSlots(IdSlots), .BucketSlots(BucketSlots)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.op(op), .addr_high(addr_high), .addr_mid(addr_mid), .addr_low(addr_low),
		.restore_id(restore_id), .restore_epoch(restore_epoch),
		.entry_id(entry_id), .status(status), .is_warm(is_warm),
		.journal_valid(journal_valid), .epoch_before(epoch_before)
	);
endmodule
